// File: hw/rtl/qvr_pkg.sv
`default_nettype none

package qvr_pkg;

    localparam int CW  = 16;
    localparam int FB  = 14;
    // sum of squares, radicand, root and remainder widths
    localparam int MW  = 2 * CW + 2;
    localparam int AW  = MW + 2 * FB;
    localparam int SW  = AW / 2;
    localparam int RW  = SW + 2;
    // quotient bits per lane and divider datapath width
    localparam int QB  = FB + 2;
    localparam int DW  = SW + QB;

    typedef enum logic [1:0] {
        REG_QUAT_W = 2'd0,
        REG_QUAT_X = 2'd1,
        REG_QUAT_Y = 2'd2,
        REG_QUAT_Z = 2'd3
    } cfg_idx_t;

    typedef struct packed {
        logic signed [CW-1:0] vec_x;
        logic signed [CW-1:0] vec_y;
        logic signed [CW-1:0] vec_z;
    } req_t;

    typedef struct packed {
        logic signed [CW-1:0] rot_x;
        logic signed [CW-1:0] rot_y;
        logic signed [CW-1:0] rot_z;
        logic                 zero_vector;
    } rsp_t;

    typedef struct packed {
        logic signed [CW-1:0] w;
        logic signed [CW-1:0] x;
        logic signed [CW-1:0] y;
        logic signed [CW-1:0] z;
    } quat_t;

    typedef struct packed {
        logic [AW-1:0] rad;
        logic [RW-1:0] rem;
        logic [SW-1:0] root;
    } sqrt_t;

    typedef struct packed {
        req_t vec;
        logic zero;
    } sqrt_side_t;

    typedef struct packed {
        logic [2:0][DW-1:0] rem;
        logic [DW-1:0]      den;
        logic [2:0][QB-1:0] quo;
    } div_t;

    typedef struct packed {
        logic [2:0] neg;
        logic       zero;
    } div_side_t;

endpackage

`default_nettype wire

// File: hw/rtl/qvr_sqrt_cell.sv
`default_nettype none

module qvr_sqrt_cell (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                adv,
    input  wire logic                in_valid,
    input  wire qvr_pkg::sqrt_t      in_data,
    input  wire qvr_pkg::sqrt_side_t in_side,
    output logic                     out_valid,
    output qvr_pkg::sqrt_t           out_data,
    output qvr_pkg::sqrt_side_t      out_side
);

    logic                valid_reg;
    qvr_pkg::sqrt_t      data_reg;
    qvr_pkg::sqrt_t      data_next;
    qvr_pkg::sqrt_side_t side_reg;
    logic [qvr_pkg::RW+1:0] rem2;
    logic [qvr_pkg::RW+1:0] trial;
    logic                   ge;

    // one root bit: bring down two radicand bits, try root*4+1
    always_comb
    begin
        rem2  = {in_data.rem, in_data.rad[qvr_pkg::AW-1 -: 2]};
        trial = {2'b00, in_data.root, 2'b01};
        ge    = (rem2 >= trial);
        data_next.rad  = in_data.rad << 2;
        data_next.rem  = ge ? qvr_pkg::RW'(rem2 - trial) : qvr_pkg::RW'(rem2);
        data_next.root = {in_data.root[qvr_pkg::SW-2:0], ge};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            data_reg <= data_next;
            side_reg <= in_side;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;
    assign out_side  = side_reg;

endmodule

`default_nettype wire

// File: hw/rtl/qvr_div_cell.sv
`default_nettype none

module qvr_div_cell (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               adv,
    input  wire logic               in_valid,
    input  wire qvr_pkg::div_t      in_data,
    input  wire qvr_pkg::div_side_t in_side,
    output logic                    out_valid,
    output qvr_pkg::div_t           out_data,
    output qvr_pkg::div_side_t      out_side
);

    logic               valid_reg;
    qvr_pkg::div_t      data_reg;
    qvr_pkg::div_t      data_next;
    qvr_pkg::div_side_t side_reg;
    logic [2:0]         ge;

    // one quotient bit for each of the three lanes, shared divisor
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            ge[i] = (in_data.rem[i] >= in_data.den);
            data_next.rem[i] = ge[i] ? (in_data.rem[i] - in_data.den) : in_data.rem[i];
            data_next.quo[i] = {in_data.quo[i][qvr_pkg::QB-2:0], ge[i]};
        end
        data_next.den = in_data.den >> 1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            data_reg <= data_next;
            side_reg <= in_side;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;
    assign out_side  = side_reg;

endmodule

`default_nettype wire

// File: hw/rtl/qvr_rotate.sv
`default_nettype none

module qvr_rotate (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          adv,
    input  wire logic                          in_valid,
    input  wire logic [2:0][qvr_pkg::QB-1:0]   quo,
    input  wire qvr_pkg::div_side_t            side,
    input  wire qvr_pkg::quat_t                quat,
    output logic                               out_valid,
    output qvr_pkg::rsp_t                      rsp
);

    localparam int NW  = qvr_pkg::FB + 2;
    localparam int PW1 = NW + qvr_pkg::CW;
    localparam int PPW = PW1 + 2;
    localparam int PW2 = PPW + qvr_pkg::CW;
    localparam int PRW = PW2 + 2;
    localparam int SH  = 2 * qvr_pkg::FB;
    localparam logic [qvr_pkg::QB-1:0] ONE = qvr_pkg::QB'(1) << qvr_pkg::FB;
    localparam logic signed [PRW-1:0] HALF = PRW'(1) << (SH - 1);
    localparam logic signed [PRW-1:0] HI   = PRW'((64'd1 << (qvr_pkg::CW - 1)) - 64'd1);
    localparam logic signed [PRW-1:0] LO   = -HI - PRW'(1);

    logic [4:0] vld_reg;
    logic [3:0] zero_reg;

    logic [qvr_pkg::QB-1:0] mag [3];
    logic signed [NW-1:0]   n_next [3];
    logic signed [NW-1:0]   n_reg [3];
    logic signed [PW1-1:0]  m1_next [12];
    logic signed [PW1-1:0]  m1_reg [12];
    logic signed [PPW-1:0]  p_next [4];
    logic signed [PPW-1:0]  p_reg [4];
    logic signed [PW2-1:0]  m2_next [12];
    logic signed [PW2-1:0]  m2_reg [12];
    logic signed [PRW-1:0]  r_sum [3];
    qvr_pkg::rsp_t          out_next;
    qvr_pkg::rsp_t          out_reg;

    function automatic logic signed [qvr_pkg::CW-1:0] round_sat(
        input logic signed [PRW-1:0] r
    );
        logic signed [PRW-1:0] f;
        f = (r + HALF) >>> SH;
        if (f > HI)
        begin
            f = HI;
        end
        else if (f < LO)
        begin
            f = LO;
        end
        return f[qvr_pkg::CW-1:0];
    endfunction

    // clamp the quotient to 1.0 and restore the sign; a zero vector gives zeros
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            mag[i] = (quo[i] > ONE) ? ONE : quo[i];
            if (side.zero)
            begin
                n_next[i] = '0;
            end
            else if (side.neg[i])
            begin
                n_next[i] = -$signed(mag[i]);
            end
            else
            begin
                n_next[i] = $signed(mag[i]);
            end
        end
    end

    // p = n * conj(q)
    always_comb
    begin
        m1_next[0]  = n_reg[0] * quat.w;
        m1_next[1]  = n_reg[1] * quat.z;
        m1_next[2]  = n_reg[2] * quat.y;
        m1_next[3]  = n_reg[1] * quat.w;
        m1_next[4]  = n_reg[2] * quat.x;
        m1_next[5]  = n_reg[0] * quat.z;
        m1_next[6]  = n_reg[2] * quat.w;
        m1_next[7]  = n_reg[0] * quat.y;
        m1_next[8]  = n_reg[1] * quat.x;
        m1_next[9]  = n_reg[0] * quat.x;
        m1_next[10] = n_reg[1] * quat.y;
        m1_next[11] = n_reg[2] * quat.z;
        p_next[0] = m1_reg[0] - m1_reg[1] + m1_reg[2];
        p_next[1] = m1_reg[3] - m1_reg[4] + m1_reg[5];
        p_next[2] = m1_reg[6] - m1_reg[7] + m1_reg[8];
        p_next[3] = m1_reg[9] + m1_reg[10] + m1_reg[11];
    end

    // r = q * p
    always_comb
    begin
        m2_next[0]  = quat.w * p_reg[0];
        m2_next[1]  = quat.x * p_reg[3];
        m2_next[2]  = quat.y * p_reg[2];
        m2_next[3]  = quat.z * p_reg[1];
        m2_next[4]  = quat.w * p_reg[1];
        m2_next[5]  = quat.y * p_reg[3];
        m2_next[6]  = quat.z * p_reg[0];
        m2_next[7]  = quat.x * p_reg[2];
        m2_next[8]  = quat.w * p_reg[2];
        m2_next[9]  = quat.z * p_reg[3];
        m2_next[10] = quat.x * p_reg[1];
        m2_next[11] = quat.y * p_reg[0];
        for (int i = 0; i < 3; i++)
        begin
            r_sum[i] = m2_reg[4*i] + m2_reg[4*i+1] + m2_reg[4*i+2] - m2_reg[4*i+3];
        end
        out_next.rot_x       = round_sat(r_sum[0]);
        out_next.rot_y       = round_sat(r_sum[1]);
        out_next.rot_z       = round_sat(r_sum[2]);
        out_next.zero_vector = zero_reg[3];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (adv)
        begin
            vld_reg <= {vld_reg[3:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            zero_reg <= {zero_reg[2:0], side.zero};
            n_reg    <= n_next;
            m1_reg   <= m1_next;
            p_reg    <= p_next;
            m2_reg   <= m2_next;
            out_reg  <= out_next;
        end
    end

    assign out_valid = vld_reg[4];
    assign rsp       = out_reg;

endmodule

`default_nettype wire

// File: hw/rtl/quaternion_vector_rotate_top.sv
// Rotates each 3-D request vector by the quaternion held in the four Q1.14
// configuration registers (w, x, y, z; reset value is a pure x rotation) after
// scaling it to unit length, and returns the rotated unit vector in Q1.14,
// saturated; an all-zero vector returns zeros with zero_vector set. The
// quaternion is used as written, so a non-unit quaternion scales the result by
// |q|^2. One request is taken every cycle unless the pipeline holds. Stages: two
// for the sum of squares, 31 cells of the square root chain (one root bit
// each), one setup stage, 16 cells of the divider chain (one quotient bit
// per cell for all three components), five for quaternion products and rounding.
// The whole pipeline holds only while a finished result is stalled at the
// output. Write the quaternion registers only while the block is empty.
`default_nettype none

module quaternion_vector_rotate_top (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   req_valid,
    output logic                        req_stall,
    input  wire qvr_pkg::req_t          req,
    output logic                        rsp_valid,
    input  wire logic                   rsp_stall,
    output qvr_pkg::rsp_t               rsp,
    input  wire logic                   cfg_we,
    input  wire logic [1:0]             cfg_index,
    input  wire logic [qvr_pkg::CW-1:0] cfg_data
);

    localparam int CW = qvr_pkg::CW;
    localparam int SW = qvr_pkg::SW;
    localparam int QB = qvr_pkg::QB;
    localparam int DW = qvr_pkg::DW;

    logic adv;

    qvr_pkg::quat_t quat_reg;

    logic                   a_vld_reg;
    qvr_pkg::req_t          a_vec_reg;
    logic signed [2*CW-1:0] sq_next [3];
    logic [2*CW-1:0]        a_sq_reg [3];

    logic                   b_vld_reg;
    qvr_pkg::req_t          b_vec_reg;
    logic [qvr_pkg::MW-1:0] b_m_reg;

    logic                sq_vld [SW+1];
    qvr_pkg::sqrt_t      sq_data [SW+1];
    qvr_pkg::sqrt_side_t sq_side [SW+1];

    logic               p_vld_reg;
    qvr_pkg::div_t      p_div_reg;
    qvr_pkg::div_t      p_div_next;
    qvr_pkg::div_side_t p_side_reg;
    qvr_pkg::div_side_t p_side_next;
    logic [CW-1:0]      vabs [3];
    logic signed [CW-1:0] vcomp [3];

    logic               dv_vld [QB+1];
    qvr_pkg::div_t      dv_data [QB+1];
    qvr_pkg::div_side_t dv_side [QB+1];

    assign adv       = !(rsp_valid && rsp_stall);
    assign req_stall = !adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            quat_reg.w <= '0;
            quat_reg.x <= CW'(1) << qvr_pkg::FB;
            quat_reg.y <= '0;
            quat_reg.z <= '0;
        end
        else if (cfg_we)
        begin
            unique case (qvr_pkg::cfg_idx_t'(cfg_index))
                qvr_pkg::REG_QUAT_W: quat_reg.w <= cfg_data;
                qvr_pkg::REG_QUAT_X: quat_reg.x <= cfg_data;
                qvr_pkg::REG_QUAT_Y: quat_reg.y <= cfg_data;
                qvr_pkg::REG_QUAT_Z: quat_reg.z <= cfg_data;
            endcase
        end
    end

    assign sq_next[0] = req.vec_x * req.vec_x;
    assign sq_next[1] = req.vec_y * req.vec_y;
    assign sq_next[2] = req.vec_z * req.vec_z;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_vld_reg <= 1'b0;
            b_vld_reg <= 1'b0;
            p_vld_reg <= 1'b0;
        end
        else if (adv)
        begin
            a_vld_reg <= req_valid;
            b_vld_reg <= a_vld_reg;
            p_vld_reg <= sq_vld[SW];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            a_vec_reg <= req;
            for (int i = 0; i < 3; i++)
            begin
                a_sq_reg[i] <= sq_next[i];
            end
            b_vec_reg  <= a_vec_reg;
            b_m_reg    <= qvr_pkg::MW'(a_sq_reg[0]) + qvr_pkg::MW'(a_sq_reg[1])
                          + qvr_pkg::MW'(a_sq_reg[2]);
            p_div_reg  <= p_div_next;
            p_side_reg <= p_side_next;
        end
    end

    assign sq_vld[0]        = b_vld_reg;
    assign sq_data[0].rad   = qvr_pkg::AW'(b_m_reg) << (2 * qvr_pkg::FB);
    assign sq_data[0].rem   = '0;
    assign sq_data[0].root  = '0;
    assign sq_side[0].vec   = b_vec_reg;
    assign sq_side[0].zero  = (b_m_reg == '0);

    for (genvar k = 0; k < SW; k++)
    begin : g_sqrt
        qvr_sqrt_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .adv       (adv),
            .in_valid  (sq_vld[k]),
            .in_data   (sq_data[k]),
            .in_side   (sq_side[k]),
            .out_valid (sq_vld[k+1]),
            .out_data  (sq_data[k+1]),
            .out_side  (sq_side[k+1])
        );
    end

    // numerator |v_i| * 2^(2*fb) + s/2, divisor aligned to the top quotient bit
    always_comb
    begin
        vcomp[0] = sq_side[SW].vec.vec_x;
        vcomp[1] = sq_side[SW].vec.vec_y;
        vcomp[2] = sq_side[SW].vec.vec_z;
        for (int i = 0; i < 3; i++)
        begin
            vabs[i] = vcomp[i][CW-1] ? CW'(-vcomp[i]) : CW'(vcomp[i]);
            p_div_next.rem[i] = (DW'(vabs[i]) << (2 * qvr_pkg::FB))
                                + DW'(sq_data[SW].root >> 1);
            p_div_next.quo[i] = '0;
            p_side_next.neg[i] = vcomp[i][CW-1];
        end
        p_div_next.den   = DW'(sq_data[SW].root) << (QB - 1);
        p_side_next.zero = sq_side[SW].zero;
    end

    assign dv_vld[0]  = p_vld_reg;
    assign dv_data[0] = p_div_reg;
    assign dv_side[0] = p_side_reg;

    for (genvar k = 0; k < QB; k++)
    begin : g_div
        qvr_div_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .adv       (adv),
            .in_valid  (dv_vld[k]),
            .in_data   (dv_data[k]),
            .in_side   (dv_side[k]),
            .out_valid (dv_vld[k+1]),
            .out_data  (dv_data[k+1]),
            .out_side  (dv_side[k+1])
        );
    end

    qvr_rotate u_rotate (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_valid  (dv_vld[QB]),
        .quo       (dv_data[QB].quo),
        .side      (dv_side[QB]),
        .quat      (quat_reg),
        .out_valid (rsp_valid),
        .rsp       (rsp)
    );

endmodule

`default_nettype wire

// File: verif/quaternion_vector_rotate_checker.sv
`default_nettype none

module quaternion_vector_rotate_checker (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   req_valid,
    input  wire logic                   req_stall,
    input  wire qvr_pkg::req_t          req,
    input  wire logic                   rsp_valid,
    input  wire logic                   rsp_stall,
    input  wire qvr_pkg::rsp_t          rsp,
    input  wire logic                   cfg_we,
    input  wire logic [1:0]             cfg_index,
    input  wire logic [qvr_pkg::CW-1:0] cfg_data,
    output int                          fail_count,
    output int                          pending
);
    timeunit 1ns;
    timeprecision 1ps;

    import qvr_pkg::*;

    localparam longint ONE = 64'sd1 <<< FB;

    quat_t quat;
    rsp_t  rot_queue[$];

    function automatic longint unsigned int_sqrt(input longint unsigned a);
        longint unsigned r;
        longint unsigned b;
        r = 0;
        b = 64'd1 << 62;
        while (b > a)
            b = b >> 2;
        while (b != 0)
        begin
            if (a >= r + b)
            begin
                a = a - (r + b);
                r = (r >> 1) + b;
            end
            else
                r = r >> 1;
            b = b >> 2;
        end
        return r;
    endfunction

    function automatic longint unit_part(input longint v, input longint unsigned s);
        longint unsigned a;
        longint unsigned q;
        a = (v < 0) ? -v : v;
        q = ((a << (2 * FB)) + (s >> 1)) / s;
        if (q > ONE)
            q = ONE;
        return (v < 0) ? -longint'(q) : longint'(q);
    endfunction

    function automatic logic signed [CW-1:0] round_clip(input longint r);
        longint f;
        // arithmetic shift gives the floor for negative values too
        f = (r + (64'sd1 <<< (2 * FB - 1))) >>> (2 * FB);
        if (f > 32767)
            f = 32767;
        if (f < -32768)
            f = -32768;
        return f[CW-1:0];
    endfunction

    function automatic rsp_t rotate_unit(input req_t v, input quat_t q);
        rsp_t o;
        longint vx, vy, vz, qw, qx, qy, qz;
        longint nx, ny, nz, px, py, pz, pw, rx, ry, rz;
        longint unsigned m, s;
        vx = v.vec_x;
        vy = v.vec_y;
        vz = v.vec_z;
        qw = q.w;
        qx = q.x;
        qy = q.y;
        qz = q.z;
        o = '0;
        m = vx * vx + vy * vy + vz * vz;
        if (m == 0)
        begin
            o.zero_vector = 1'b1;
            return o;
        end
        s = int_sqrt(m << (2 * FB));
        nx = unit_part(vx, s);
        ny = unit_part(vy, s);
        nz = unit_part(vz, s);
        px = nx * qw - ny * qz + nz * qy;
        py = ny * qw - nz * qx + nx * qz;
        pz = nz * qw - nx * qy + ny * qx;
        pw = nx * qx + ny * qy + nz * qz;
        rx = qw * px + qx * pw + qy * pz - qz * py;
        ry = qw * py + qy * pw + qz * px - qx * pz;
        rz = qw * pz + qz * pw + qx * py - qy * px;
        o.rot_x = round_clip(rx);
        o.rot_y = round_clip(ry);
        o.rot_z = round_clip(rz);
        return o;
    endfunction

    assign pending = rot_queue.size();

    always @(posedge clk or negedge rst_n)
    begin
        rsp_t exp_rot;
        if (!rst_n)
        begin
            quat.w = '0;
            quat.x = CW'(ONE);
            quat.y = '0;
            quat.z = '0;
            fail_count = 0;
            rot_queue.delete();
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_idx_t'(cfg_index))
                    REG_QUAT_W: quat.w = cfg_data;
                    REG_QUAT_X: quat.x = cfg_data;
                    REG_QUAT_Y: quat.y = cfg_data;
                    REG_QUAT_Z: quat.z = cfg_data;
                    default: ;
                endcase
            end
            if (req_valid && !req_stall)
                rot_queue.push_back(rotate_unit(req, quat));
            if (rsp_valid && !rsp_stall)
            begin
                if (rot_queue.size() == 0)
                begin
                    $error("result with no request outstanding");
                    fail_count++;
                end
                else
                begin
                    exp_rot = rot_queue.pop_front();
                    if (rsp.rot_x !== exp_rot.rot_x)
                        $error("rot_x expected %0d got %0d", exp_rot.rot_x, rsp.rot_x);
                    if (rsp.rot_y !== exp_rot.rot_y)
                        $error("rot_y expected %0d got %0d", exp_rot.rot_y, rsp.rot_y);
                    if (rsp.rot_z !== exp_rot.rot_z)
                        $error("rot_z expected %0d got %0d", exp_rot.rot_z, rsp.rot_z);
                    if (rsp.zero_vector !== exp_rot.zero_vector)
                        $error("zero_vector expected %0d got %0d",
                               exp_rot.zero_vector, rsp.zero_vector);
                    if (rsp !== exp_rot)
                        fail_count++;
                end
            end
        end
    end

endmodule

`default_nettype wire

// File: verif/quaternion_vector_rotate_top_tb.sv
`default_nettype none

module quaternion_vector_rotate_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import qvr_pkg::*;

    localparam int LATENCY     = 60;
    localparam int CYCLE_LIMIT = 1000000;
    localparam int PHASE_ITEMS = 300;

    logic          clk;
    logic          rst_n;
    logic          req_valid;
    logic          req_stall;
    req_t          req;
    logic          rsp_valid;
    logic          rsp_stall;
    rsp_t          rsp;
    logic          cfg_we;
    logic [1:0]    cfg_index;
    logic [CW-1:0] cfg_data;
    int            fail_count;
    int            pending;
    int            sent;
    int            cycles;

    quaternion_vector_rotate_top i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    quaternion_vector_rotate_checker i_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .req_valid  (req_valid),
        .req_stall  (req_stall),
        .req        (req),
        .rsp_valid  (rsp_valid),
        .rsp_stall  (rsp_stall),
        .rsp        (rsp),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .fail_count (fail_count),
        .pending    (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        cycles = 0;
        forever
        begin
            @(posedge clk);
            cycles++;
            if (cycles > CYCLE_LIMIT)
            begin
                $display("Test completed with failures");
                $finish;
            end
        end
    end

    // receiver: random stall runs plus one long hold-off once 100 requests are sent
    initial
    begin
        int run_left;
        logic held;
        rsp_stall = 1'b0;
        run_left = 0;
        held = 1'b0;
        forever
        begin
            @(negedge clk);
            if (!held && sent >= 100)
            begin
                held = 1'b1;
                rsp_stall = 1'b1;
                repeat (200) @(negedge clk);
                rsp_stall = 1'b0;
            end
            else if (run_left > 0)
                run_left--;
            else
            begin
                rsp_stall = ($urandom_range(0, 3) == 0);
                run_left = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60)
                                                       : $urandom_range(0, 4);
            end
        end
    end

    task automatic write_reg(input cfg_idx_t idx, input logic [CW-1:0] value);
        @(negedge clk);
        cfg_we = 1'b1;
        cfg_index = idx;
        cfg_data = value;
        @(negedge clk);
        cfg_we = 1'b0;
    endtask

    task automatic load_quat(input quat_t q);
        // stop offering before draining, or the last request is taken again
        @(negedge clk);
        req_valid = 1'b0;
        wait (pending == 0);
        repeat (LATENCY) @(posedge clk);
        write_reg(REG_QUAT_W, q.w);
        write_reg(REG_QUAT_X, q.x);
        write_reg(REG_QUAT_Y, q.y);
        write_reg(REG_QUAT_Z, q.z);
    endtask

    task automatic send_vec(input logic [CW-1:0] x, input logic [CW-1:0] y,
                            input logic [CW-1:0] z);
        int gap;
        int pick;
        @(negedge clk);
        req_valid = 1'b1;
        req.vec_x = x;
        req.vec_y = y;
        req.vec_z = z;
        do
            @(posedge clk);
        while (req_stall);
        sent++;
        pick = $urandom_range(0, 19);
        gap = (pick < 12) ? 0 : (pick < 19) ? $urandom_range(1, 3) : $urandom_range(20, 50);
        if (gap > 0)
        begin
            @(negedge clk);
            req_valid = 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
    endtask

    function automatic logic [CW-1:0] rand_comp(input int mode);
        case (mode)
            0: return '0;
            1: return CW'($urandom_range(0, 8) - 4);
            2: return ($urandom_range(0, 1) != 0) ? 16'h7fff : 16'h8000;
            default: return CW'($urandom);
        endcase
    endfunction

    task automatic send_random;
        int mode;
        mode = $urandom_range(0, 19);
        if (mode == 0)
            send_vec('0, '0, '0);
        else if (mode < 4)
            send_vec(rand_comp(1), rand_comp(1), rand_comp(1));
        else if (mode < 6)
            send_vec(rand_comp($urandom_range(0, 3)), rand_comp($urandom_range(0, 3)),
                     rand_comp($urandom_range(0, 3)));
        else
            send_vec(rand_comp(3), rand_comp(3), rand_comp(3));
    endtask

    initial
    begin
        quat_t q;
        rst_n = 1'b0;
        req_valid = 1'b0;
        req = '0;
        cfg_we = 1'b0;
        cfg_index = REG_QUAT_W;
        cfg_data = '0;
        sent = 0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed vectors under the reset quaternion
        send_vec(16'h0000, 16'h0000, 16'h0000);
        send_vec(16'h7fff, 16'h0000, 16'h0000);
        send_vec(16'h8000, 16'h0000, 16'h0000);
        send_vec(16'h0000, 16'h7fff, 16'h0000);
        send_vec(16'h0000, 16'h0000, 16'h8000);
        send_vec(16'h0001, 16'h0000, 16'h0000);
        send_vec(16'hffff, 16'h0000, 16'h0000);
        send_vec(16'h0001, 16'h0001, 16'h0001);
        send_vec(16'h7fff, 16'h7fff, 16'h7fff);
        send_vec(16'h8000, 16'h8000, 16'h8000);
        send_vec(16'h8000, 16'h7fff, 16'h0001);
        send_vec(16'h0003, 16'hfffc, 16'h0000);
        send_vec(16'h5555, 16'haaaa, 16'h0f0f);
        repeat (PHASE_ITEMS) send_random();

        for (int phase = 0; phase < 5; phase++)
        begin
            case (phase)
                0: q = '{w: 16'sd16384, x: 16'sd0, y: 16'sd0, z: 16'sd0};
                // non-unit quaternion, result scales by four and saturates
                1: q = '{w: -16'sd16384, x: -16'sd16384, y: -16'sd16384, z: -16'sd16384};
                2: q = '{w: 16'sh7fff, x: 16'sh8000, y: 16'sh7fff, z: 16'sh8000};
                3: q = '{w: 16'sd11585, x: 16'sd0, y: 16'sd11585, z: -16'sd16384};
                default: q = '{w: CW'($urandom), x: CW'($urandom), y: CW'($urandom),
                               z: CW'($urandom)};
            endcase
            load_quat(q);
            send_vec(16'h7fff, 16'h0000, 16'h0000);
            send_vec(16'h0000, 16'h0000, 16'h0000);
            repeat (PHASE_ITEMS) send_random();
        end

        @(negedge clk);
        req_valid = 1'b0;
        wait (pending == 0);
        repeat (LATENCY) @(posedge clk);
        if (fail_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

`default_nettype wire
